// ===== rtl/dfcg_pkg.sv =====
`default_nettype none

package dfcg_pkg;

  localparam int MAX_DEPS_DEFAULT = 8;
  localparam logic [63:0] AGE_UNBOUNDED = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_UPDATE = 2'd1,
    FN_INVAL  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // One stored dependency element of the signature.
  typedef struct packed {
    logic [7:0]  kind;
    logic [31:0] subject_key;
    logic [63:0] subject_rev;
    logic [31:0] dep_episode;
    logic [63:0] dep_timestamp;
    logic [63:0] max_age;
  } sig_elem_t;

  localparam int SIG_W = $bits(sig_elem_t);

endpackage

`default_nettype wire

// ===== rtl/dfcg_ram.sv =====
`default_nettype none

module dfcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfcg_fresh.sv =====
`default_nettype none

module dfcg_fresh
  import dfcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] dep_episode,
  input  wire logic [63:0] dep_timestamp,
  input  wire logic [63:0] max_age,
  input  wire logic [31:0] now_episode,
  input  wire logic [63:0] now_timestamp,
  output logic             fresh
);

  logic [63:0] age;
  logic        fresh_next;

  // Age only matters when the stamp is not in the future, so wrap is harmless.
  assign age = now_timestamp - dep_timestamp;

  always_comb begin
    fresh_next = (dep_episode == now_episode) && (dep_timestamp <= now_timestamp) &&
                 ((max_age == AGE_UNBOUNDED) || (age <= max_age));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fresh <= fresh_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dependency_freshness_cache_guard.sv =====
// Dependency freshness cache guard.
// Request channel (req_valid / req_ready) carries one dependency element of a
// call: func selects lookup, update or invalidate, count gives the call's
// element count. The last element of a lookup or update call produces one
// response on rsp_valid / rsp_ready: hit, status (1 = update count rejected)
// and the running hit and miss totals. Invalidate gives no response.
// A request passes an accept step and a compare step: the accept edge reads the
// signature memory at the element index and evaluates freshness, then the compare
// stage compares against the read data and its commit edge writes back on update
// and loads the response register. No request is accepted until the previous one
// commits; the response shows right after the commit edge.
// When the response register is still held by a stalled receiver, a request
// that would produce a response waits in the compare stage and req_ready stays
// low until the receiver takes the older response.
// Reset clears the guard, the stored length, both totals and the call
// framing. The signature memory is not cleared; a lookup may compare against
// unwritten entries, but it cannot hit until a completed update sets the guard.
`default_nettype none

module dependency_freshness_cache_guard
  import dfcg_pkg::*;
#(
  parameter int MAX_DEPS = MAX_DEPS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  count,
  input  wire logic [7:0]  kind,
  input  wire logic [31:0] subject_key,
  input  wire logic [63:0] subject_rev,
  input  wire logic [31:0] dep_episode,
  input  wire logic [63:0] dep_timestamp,
  input  wire logic [63:0] max_age,
  input  wire logic [31:0] now_episode,
  input  wire logic [63:0] now_timestamp,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic             hit,
  output logic             status,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total
);

  localparam int AW = (MAX_DEPS > 1) ? $clog2(MAX_DEPS) : 1;
  localparam int LW = $clog2(MAX_DEPS + 1);

  state_t          state, state_next;
  logic [7:0]      element_index;
  logic            running_match;
  logic            guard_valid;
  logic [LW-1:0]   sig_length;
  logic [31:0]     hits_kept;
  logic [31:0]     misses_kept;

  func_t           func_q;
  logic [7:0]      count_q;
  sig_elem_t       elem_q;
  logic            range_q;

  sig_elem_t       elem_in;
  logic [SIG_W-1:0] rd_data;
  logic            fresh_q;
  logic            accept;
  logic            in_range;

  logic            last;
  logic            gives_rsp;
  logic            commit;
  logic            run_new;
  logic            hit_now;
  logic            upd_ok;
  logic            mem_we;

  assign accept   = req_valid && req_ready;
  assign in_range = element_index < 8'(MAX_DEPS);

  always_comb begin
    elem_in.kind          = kind;
    elem_in.subject_key   = subject_key;
    elem_in.subject_rev   = subject_rev;
    elem_in.dep_episode   = dep_episode;
    elem_in.dep_timestamp = dep_timestamp;
    elem_in.max_age       = max_age;
  end

  dfcg_ram #(
    .WIDTH (SIG_W),
    .DEPTH (MAX_DEPS),
    .AW    (AW)
  ) u_sig_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (element_index[AW-1:0]),
    .wdata (elem_q),
    .re    (accept && in_range),
    .raddr (element_index[AW-1:0]),
    .rdata (rd_data)
  );

  dfcg_fresh u_fresh (
    .clk           (clk),
    .en            (accept),
    .dep_episode   (dep_episode),
    .dep_timestamp (dep_timestamp),
    .max_age       (max_age),
    .now_episode   (now_episode),
    .now_timestamp (now_timestamp),
    .fresh         (fresh_q)
  );

  // Capture the request; memory read and freshness run in the same edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func_t'(func);
      count_q <= count;
      elem_q  <= elem_in;
      range_q <= in_range;
    end
  end

  // Compare stage datapath.
  always_comb begin
    last      = ({1'b0, element_index} + 9'd1) >= {1'b0, count_q};
    gives_rsp = ((func_q == FN_LOOKUP) || (func_q == FN_UPDATE)) && last;
    commit    = (state == ST_EXEC) && (!gives_rsp || !rsp_valid || rsp_ready);
    run_new   = running_match;
    if (count_q != 8'd0) begin
      run_new = running_match && fresh_q && (!range_q || (sig_elem_t'(rd_data) == elem_q));
    end
    hit_now   = guard_valid && (count_q == 8'(sig_length)) && run_new;
    upd_ok    = (count_q != 8'd0) && (count_q <= 8'(MAX_DEPS));
    mem_we    = commit && (func_q == FN_UPDATE) && upd_ok && range_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Guard, framing and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
      running_match <= 1'b1;
      guard_valid   <= 1'b0;
      sig_length    <= '0;
      hits_kept     <= '0;
      misses_kept   <= '0;
    end else if (commit) begin
      unique case (func_q)
        FN_INVAL: begin
          guard_valid   <= 1'b0;
          sig_length    <= '0;
          element_index <= '0;
          running_match <= 1'b1;
        end
        FN_LOOKUP: begin
          if (last) begin
            element_index <= '0;
            running_match <= 1'b1;
            if (hit_now) begin
              hits_kept <= hits_kept + 32'd1;
            end else begin
              misses_kept <= misses_kept + 32'd1;
            end
          end else begin
            element_index <= element_index + 8'd1;
            running_match <= run_new;
          end
        end
        FN_UPDATE: begin
          if (upd_ok) begin
            guard_valid <= last;
          end
          if (last) begin
            element_index <= '0;
            running_match <= 1'b1;
            if (upd_ok) begin
              sig_length <= count_q[LW-1:0];
            end
          end else begin
            element_index <= element_index + 8'd1;
          end
        end
        FN_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Response register: hold until taken, load at a committing last element.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit && gives_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && gives_rsp) begin
      if (func_q == FN_LOOKUP) begin
        hit        <= hit_now;
        status     <= 1'b0;
        hit_total  <= hit_now ? hits_kept + 32'd1 : hits_kept;
        miss_total <= hit_now ? misses_kept : misses_kept + 32'd1;
      end else begin
        hit        <= 1'b0;
        status     <= !upd_ok;
        hit_total  <= hits_kept;
        miss_total <= misses_kept;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dfcg_checker.sv =====
`default_nettype none

module dfcg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic        hit,
  input wire logic        status,
  input wire logic [31:0] hit_total,
  input wire logic [31:0] miss_total
);

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(hit) && $stable(status) &&
       $stable(hit_total) && $stable(miss_total)))
    else $error("response dropped or changed while stalled");

  // One request in flight: the cycle after an accept is busy.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (!rst && req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while the previous one is in flight");

  // Reset empties the response register.
  a_rst_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A hit is never a rejected update.
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(hit && status))
    else $error("hit reported together with rejected status");

endmodule

bind dependency_freshness_cache_guard dfcg_checker u_dfcg_checker (.*);

`default_nettype wire
